@@ rtl/wsfr_pkg.sv @@
package wsfr_pkg;

  localparam int PayloadLenBitsDef = 63;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_ELENGTH = 3'd2,
    PH_MASKKEY = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    ERR_RSV        = 4'd0,
    ERR_OPCODE     = 4'd1,
    ERR_FRAG_CTRL  = 4'd2,
    ERR_ORPHAN     = 4'd3,
    ERR_NEW_DATA   = 4'd4,
    ERR_CTRL_EXT   = 4'd5,
    ERR_MASK       = 4'd6,
    ERR_MSB        = 4'd7,
    ERR_NONMINIMAL = 4'd8,
    ERR_CLOSE_LEN1 = 4'd9,
    ERR_CLOSE_STAT = 4'd10
  } cause_t;

  localparam logic [3:0] OPC_CONT  = 4'd0;
  localparam logic [3:0] OPC_TEXT  = 4'd1;
  localparam logic [3:0] OPC_BIN   = 4'd2;
  localparam logic [3:0] OPC_CLOSE = 4'd8;
  localparam logic [3:0] OPC_PING  = 4'd9;
  localparam logic [3:0] OPC_PONG  = 4'd10;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_is_control;
    logic       message_start;
    logic [3:0] message_opcode;
    logic       message_end;
    logic       protocol_error;
    logic [3:0] error_cause;
  } result_t;

  function automatic logic close_status_ok(input logic [15:0] s);
    return (s >= 16'd1000 && s <= 16'd1014 && s != 16'd1004 && s != 16'd1005 &&
            s != 16'd1006) || (s >= 16'd3000 && s <= 16'd4999);
  endfunction

endpackage

@@ rtl/wsfr_parser.sv @@
module wsfr_parser #(
  parameter int PAYLOAD_LEN_BITS = wsfr_pkg::PayloadLenBitsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic              masking_expected,
  output wsfr_pkg::result_t res
);
  import wsfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        fin_r, fin_nxt, mflag_r, mflag_nxt, ctrl_r, ctrl_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic [6:0]  lcode_r, lcode_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [63:0] ext_r, ext_nxt;
  logic [PAYLOAD_LEN_BITS-1:0] rem_r, rem_nxt;
  logic [1:0]  off_r, off_nxt;
  logic [31:0] key_r, key_nxt;
  logic [2:0]  key_left_r, key_left_nxt;
  logic        frag_r, frag_nxt;
  logic [15:0] cstat_r, cstat_nxt;
  logic [6:0]  ccnt_r, ccnt_nxt;

  // per-byte transition
  always_comb begin
    logic [3:0]  op;
    logic        f, c;
    logic [7:0]  d;
    logic [1:0]  kidx;
    logic        clear, finish;
    logic [63:0] sh;
    logic [3:0]  el;
    logic [2:0]  kl;
    logic [PAYLOAD_LEN_BITS-1:0] rm;
    logic [6:0]  cc;
    logic [15:0] cs;
    phase_nxt = phase_r; fin_nxt = fin_r; mflag_nxt = mflag_r; ctrl_nxt = ctrl_r;
    opc_nxt = opc_r; lcode_nxt = lcode_r; ext_left_nxt = ext_left_r; ext_nxt = ext_r;
    rem_nxt = rem_r; off_nxt = off_r; key_nxt = key_r; key_left_nxt = key_left_r;
    frag_nxt = frag_r; cstat_nxt = cstat_r; ccnt_nxt = ccnt_r;
    res = '0;
    clear = 1'b0; finish = 1'b0;
    op = rx_byte[3:0]; f = rx_byte[7]; c = rx_byte[3];
    d = rx_byte; kidx = 2'd0; sh = '0; el = '0; kl = '0; rm = '0; cc = '0; cs = '0;
    case (phase_r)
      PH_LENGTH: begin
        mflag_nxt = rx_byte[7];
        if (rx_byte[7] != masking_expected) begin
          res.protocol_error = 1'b1; res.error_cause = ERR_MASK; clear = 1'b1;
        end else begin
          lcode_nxt = rx_byte[6:0];
          rem_nxt = PAYLOAD_LEN_BITS'(rx_byte[6:0]);
          if (ctrl_r && rx_byte[6:0] > 7'd125) begin
            res.protocol_error = 1'b1; res.error_cause = ERR_CTRL_EXT; clear = 1'b1;
          end else if (rx_byte[6:0] > 7'd125) begin
            ext_left_nxt = (rx_byte[6:0] == 7'd126) ? 4'd2 : 4'd8;
            ext_nxt = '0; rem_nxt = '0; phase_nxt = PH_ELENGTH;
          end else if (rx_byte[7]) begin
            phase_nxt = PH_MASKKEY;
          end else if (rx_byte[6:0] != 7'd0) begin
            phase_nxt = PH_PAYLOAD;
          end else begin
            finish = 1'b1;
          end
        end
      end
      PH_ELENGTH: begin
        sh = {ext_r[55:0], rx_byte};
        ext_nxt = sh;
        el = (ext_left_r != 4'd0) ? ext_left_r - 4'd1 : 4'd0;
        ext_left_nxt = el;
        if (el == 4'd0) begin
          if ((sh >> PAYLOAD_LEN_BITS) != 64'd0) begin
            res.protocol_error = 1'b1; res.error_cause = ERR_MSB; clear = 1'b1;
          end else if ((lcode_r == 7'd126 && sh < 64'd126) ||
                       (lcode_r == 7'd127 && sh < 64'd65536)) begin
            res.protocol_error = 1'b1; res.error_cause = ERR_NONMINIMAL; clear = 1'b1;
          end else begin
            rem_nxt = sh[PAYLOAD_LEN_BITS-1:0];
            phase_nxt = mflag_r ? PH_MASKKEY : PH_PAYLOAD;
          end
        end
      end
      PH_MASKKEY: begin
        kidx = 2'(3'd4 - key_left_r);
        key_nxt[8*kidx +: 8] = rx_byte;
        kl = (key_left_r != 3'd0) ? key_left_r - 3'd1 : 3'd0;
        key_left_nxt = kl;
        if (kl == 3'd0) begin
          if (rem_r != '0) phase_nxt = PH_PAYLOAD;
          else finish = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (mflag_r) d = rx_byte ^ key_r[8*off_r +: 8];
        off_nxt = off_r + 2'd1;
        res.data_valid = 1'b1; res.data_byte = d; res.data_is_control = ctrl_r;
        cc = ccnt_r; cs = cstat_r;
        if (ctrl_r) begin
          if (ccnt_r < 7'd2) cs = {cstat_r[7:0], d};
          if (ccnt_r < 7'd127) cc = ccnt_r + 7'd1;
        end
        cstat_nxt = cs; ccnt_nxt = cc;
        rm = (rem_r != '0) ? rem_r - 1'b1 : '0;
        rem_nxt = rm;
        if (rm == '0) begin
          if (opc_r == OPC_CLOSE && cc == 7'd1) begin
            res.protocol_error = 1'b1; res.error_cause = ERR_CLOSE_LEN1; clear = 1'b1;
          end else if (opc_r == OPC_CLOSE && cc >= 7'd2 && !close_status_ok(cs)) begin
            res.protocol_error = 1'b1; res.error_cause = ERR_CLOSE_STAT; clear = 1'b1;
          end else begin
            finish = 1'b1;
          end
        end
      end
      default: begin
        fin_nxt = f; opc_nxt = op; ctrl_nxt = c;
        if (rx_byte[6:4] != 3'd0) begin
          res.protocol_error = 1'b1; res.error_cause = ERR_RSV; clear = 1'b1;
        end else if (!(op == OPC_CONT || op == OPC_TEXT || op == OPC_BIN ||
                       op == OPC_CLOSE || op == OPC_PING || op == OPC_PONG)) begin
          res.protocol_error = 1'b1; res.error_cause = ERR_OPCODE; clear = 1'b1;
        end else if (c && !f) begin
          res.protocol_error = 1'b1; res.error_cause = ERR_FRAG_CTRL; clear = 1'b1;
        end else if (op == OPC_CONT) begin
          if (!frag_r) begin
            res.protocol_error = 1'b1; res.error_cause = ERR_ORPHAN; clear = 1'b1;
          end else phase_nxt = PH_LENGTH;
        end else if (c) begin
          res.message_start = 1'b1; res.message_opcode = op; phase_nxt = PH_LENGTH;
        end else if (frag_r) begin
          res.protocol_error = 1'b1; res.error_cause = ERR_NEW_DATA; clear = 1'b1;
        end else begin
          res.message_start = 1'b1; res.message_opcode = op;
          if (!f) frag_nxt = 1'b1;
          phase_nxt = PH_LENGTH;
        end
      end
    endcase
    // frame completion
    if (finish) begin
      if (opc_nxt == OPC_CONT && fin_nxt) frag_nxt = 1'b0;
      res.message_end = fin_nxt;
      clear = 1'b1;
    end
    if (clear) begin
      phase_nxt = PH_OPCODE; fin_nxt = 1'b0; mflag_nxt = 1'b0; ctrl_nxt = 1'b0;
      opc_nxt = '0; lcode_nxt = '0; ext_left_nxt = '0; ext_nxt = '0; rem_nxt = '0;
      off_nxt = '0; key_left_nxt = 3'd4; cstat_nxt = '0; ccnt_nxt = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE; fin_r <= 1'b0; mflag_r <= 1'b0; ctrl_r <= 1'b0;
      opc_r <= '0; lcode_r <= '0; ext_left_r <= '0; ext_r <= '0; rem_r <= '0;
      off_r <= '0; key_r <= '0; key_left_r <= 3'd4; frag_r <= 1'b0;
      cstat_r <= '0; ccnt_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; fin_r <= fin_nxt; mflag_r <= mflag_nxt; ctrl_r <= ctrl_nxt;
      opc_r <= opc_nxt; lcode_r <= lcode_nxt; ext_left_r <= ext_left_nxt;
      ext_r <= ext_nxt; rem_r <= rem_nxt; off_r <= off_nxt; key_r <= key_nxt;
      key_left_r <= key_left_nxt; frag_r <= frag_nxt; cstat_r <= cstat_nxt;
      ccnt_r <= ccnt_nxt;
    end
  end

endmodule

@@ rtl/websocket_frame_receiver.sv @@
// WebSocket frame receiver: parses one received byte per request.
// Input channel: in_valid / in_stall / in_rx_byte. Each byte accepted
// (valid high, stall low) produces exactly one result request on the out_
// channel carrying unmasked payload, message start/end and error flags.
// Configuration: cfg_we / cfg_masking_expected, written while idle.
// Timing: a byte is registered at acceptance and parsed into the result
// register when the parser steps, which out_stall can hold off.
// Throughput: one byte per cycle unless out_stall holds the result
// register, set by the single-pass parser between the two registers.
// Stall: when out_stall holds the result register, the input register
// keeps its byte and in_stall rises only when both are full, so the stream
// keeps moving at full rate while the receiver takes results.
// Reset (rst_n low, synchronous): parser returns to the opcode phase, no
// fragmented message is open, masking_expected is 1, both registers empty.
module websocket_frame_receiver #(
  parameter int PAYLOAD_LEN_BITS = wsfr_pkg::PayloadLenBitsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_data_valid,
  output logic [7:0] out_data_byte,
  output logic       out_data_is_control,
  output logic       out_message_start,
  output logic [3:0] out_message_opcode,
  output logic       out_message_end,
  output logic       out_protocol_error,
  output logic [3:0] out_error_cause,
  input  logic       cfg_we,
  input  logic       cfg_masking_expected
);
  import wsfr_pkg::*;

  logic       mexp_r;
  logic       iv_r;
  logic [7:0] ib_r;
  logic       ov_r;
  result_t    res_r;
  result_t    res;
  logic       step;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) mexp_r <= 1'b1;
    else if (cfg_we) mexp_r <= cfg_masking_expected;
  end

  assign step     = iv_r && (!ov_r || !out_stall);
  assign in_stall = iv_r && !step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (!in_stall) iv_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) ib_r <= in_rx_byte;
  end

  wsfr_parser #(.PAYLOAD_LEN_BITS(PAYLOAD_LEN_BITS)) u_parser (
    .clk(clk), .rst_n(rst_n), .step(step), .rx_byte(ib_r),
    .masking_expected(mexp_r), .res(res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (!ov_r || !out_stall) ov_r <= step;
  end
  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  assign out_valid           = ov_r;
  assign out_data_valid      = res_r.data_valid;
  assign out_data_byte       = res_r.data_byte;
  assign out_data_is_control = res_r.data_is_control;
  assign out_message_start   = res_r.message_start;
  assign out_message_opcode  = res_r.message_opcode;
  assign out_message_end     = res_r.message_end;
  assign out_protocol_error  = res_r.protocol_error;
  assign out_error_cause     = res_r.error_cause;

  // an error result never carries message end
  a_err_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_protocol_error |-> !out_message_end)
    else $error("error with message end");

  // a stepped byte always lands in the result register
  a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid)
    else $error("result lost");

  // start never shares a result with payload or an error
  a_start_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_start |-> !out_data_valid && !out_protocol_error)
    else $error("start with data or error");

endmodule

@@ test/websocket_frame_receiver_tb.sv @@
`timescale 1ns / 1ps

module websocket_frame_receiver_tb;
  import wsfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_data_valid;
  logic [7:0] out_data_byte;
  logic       out_data_is_control;
  logic       out_message_start;
  logic [3:0] out_message_opcode;
  logic       out_message_end;
  logic       out_protocol_error;
  logic [3:0] out_error_cause;
  logic       cfg_we;
  logic       cfg_masking_expected;

  websocket_frame_receiver dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data_valid      (out_data_valid),
    .out_data_byte       (out_data_byte),
    .out_data_is_control (out_data_is_control),
    .out_message_start   (out_message_start),
    .out_message_opcode  (out_message_opcode),
    .out_message_end     (out_message_end),
    .out_protocol_error  (out_protocol_error),
    .out_error_cause     (out_error_cause),
    .cfg_we              (cfg_we),
    .cfg_masking_expected(cfg_masking_expected)
  );

  // parser state mirror
  logic        mask_req;
  phase_t      ph;
  logic        fin_q, masked_q, ctrl_q;
  logic [3:0]  opc_q;
  logic [6:0]  len_code;
  logic [3:0]  ext_left;
  logic [63:0] ext_acc;
  logic [62:0] remaining;
  logic [1:0]  offset;
  logic [31:0] key;
  logic [2:0]  key_left;
  logic        frag_open;
  logic [15:0] close_code;
  logic [6:0]  ctrl_cnt;

  result_t pending_results[$];
  int      error_count;
  int      bytes_sent;
  int      results_seen;
  int      errors_flagged;
  int      idle_cycles;
  bit      timed_out;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_frame_state();
    ph = PH_OPCODE;
    fin_q = 0; masked_q = 0; ctrl_q = 0; opc_q = OPC_CONT;
    len_code = 0; ext_left = 0; ext_acc = 0; remaining = 0;
    offset = 0; key_left = 3'd4; close_code = 0; ctrl_cnt = 0;
  endfunction

  function automatic void flag_error(ref result_t r, input cause_t c);
    r.protocol_error = 1'b1;
    r.error_cause = c;
    clear_frame_state();
  endfunction

  function automatic void complete_frame(ref result_t r);
    if (opc_q == OPC_CONT && fin_q) frag_open = 0;
    if (fin_q) r.message_end = 1'b1;
    clear_frame_state();
  endfunction

  function automatic bit opcode_known(input logic [3:0] op);
    return op == OPC_CONT || op == OPC_TEXT || op == OPC_BIN ||
           op == OPC_CLOSE || op == OPC_PING || op == OPC_PONG;
  endfunction

  function automatic bit close_code_valid(input logic [15:0] s);
    return (s >= 1000 && s <= 1014 && s != 1004 && s != 1005 && s != 1006) ||
           (s >= 3000 && s <= 4999);
  endfunction

  // one byte through the parser mirror
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    logic [7:0] d;
    int idx;
    r = '0;
    case (ph)
      PH_LENGTH: begin
        masked_q = b[7];
        if (masked_q != mask_req) flag_error(r, ERR_MASK);
        else begin
          len_code = b[6:0];
          remaining = 63'(len_code);
          if (ctrl_q && len_code > 125) flag_error(r, ERR_CTRL_EXT);
          else if (len_code > 125) begin
            ext_left = (len_code == 126) ? 4'd2 : 4'd8;
            ext_acc = 0;
            remaining = 0;
            ph = PH_ELENGTH;
          end else if (masked_q) ph = PH_MASKKEY;
          else if (remaining > 0) ph = PH_PAYLOAD;
          else complete_frame(r);
        end
      end
      PH_ELENGTH: begin
        ext_acc = {ext_acc[55:0], b};
        if (ext_left > 0) ext_left--;
        if (ext_left == 0) begin
          if (ext_acc[63]) flag_error(r, ERR_MSB);
          else if ((len_code == 126 && ext_acc < 126) ||
                   (len_code == 127 && ext_acc < 65536)) flag_error(r, ERR_NONMINIMAL);
          else begin
            remaining = ext_acc[62:0];
            ph = masked_q ? PH_MASKKEY : PH_PAYLOAD;
          end
        end
      end
      PH_MASKKEY: begin
        idx = (4 - key_left) & 3;
        key[idx*8 +: 8] = b;
        if (key_left > 0) key_left--;
        if (key_left == 0) begin
          if (remaining > 0) ph = PH_PAYLOAD;
          else complete_frame(r);
        end
      end
      PH_PAYLOAD: begin
        d = masked_q ? (b ^ key[offset*8 +: 8]) : b;
        offset = offset + 2'd1;
        r.data_valid = 1'b1;
        r.data_byte = d;
        r.data_is_control = ctrl_q;
        if (ctrl_q) begin
          if (ctrl_cnt < 2) close_code = {close_code[7:0], d};
          if (ctrl_cnt < 127) ctrl_cnt++;
        end
        if (remaining > 0) remaining--;
        if (remaining == 0) begin
          if (opc_q == OPC_CLOSE && ctrl_cnt == 1) flag_error(r, ERR_CLOSE_LEN1);
          else if (opc_q == OPC_CLOSE && ctrl_cnt >= 2 && !close_code_valid(close_code))
            flag_error(r, ERR_CLOSE_STAT);
          else complete_frame(r);
        end
      end
      default: begin
        fin_q = b[7];
        opc_q = b[3:0];
        ctrl_q = opc_q >= 8;
        if (b[6:4] != 0) flag_error(r, ERR_RSV);
        else if (!opcode_known(opc_q)) flag_error(r, ERR_OPCODE);
        else if (ctrl_q && !fin_q) flag_error(r, ERR_FRAG_CTRL);
        else if (opc_q == OPC_CONT) begin
          if (!frag_open) flag_error(r, ERR_ORPHAN);
          else ph = PH_LENGTH;
        end else if (ctrl_q) begin
          r.message_start = 1'b1;
          r.message_opcode = opc_q;
          ph = PH_LENGTH;
        end else if (frag_open) flag_error(r, ERR_NEW_DATA);
        else begin
          r.message_start = 1'b1;
          r.message_opcode = opc_q;
          if (!fin_q) frag_open = 1;
          ph = PH_LENGTH;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got,
             want);
    error_count++;
  endtask

  // sends one byte, predicting its result at acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(parse_byte(b));
    if (pending_results[$].protocol_error) errors_flagged++;
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask_mode(input logic m);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_masking_expected <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mask_req = m;
  endtask

  // whole frame with chosen header details
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic mask,
                            input int len, input int len_form, input bit close_ok);
    logic [31:0] k;
    logic [7:0]  p;
    k = $urandom;
    send_byte({fin, 3'b000, op});
    if (len_form == 0) send_byte({mask, 7'(len)});
    else if (len_form == 1) begin
      send_byte({mask, 7'd126});
      send_byte(8'(len >> 8));
      send_byte(8'(len));
    end else begin
      send_byte({mask, 7'd127});
      repeat (5) send_byte(8'h00);
      send_byte(8'(len >> 16));
      send_byte(8'(len >> 8));
      send_byte(8'(len));
    end
    if (mask) for (int i = 0; i < 4; i++) send_byte(k[i*8 +: 8]);
    for (int i = 0; i < len; i++) begin
      p = 8'($urandom);
      if (close_ok && i == 0) p = 8'h03;
      if (close_ok && i == 1) p = 8'hE8;
      send_byte(mask ? (p ^ k[(i%4)*8 +: 8]) : p);
    end
  endtask

  task automatic test_header_errors();
    write_mask_mode(1'b1);
    send_byte(8'hF1);                    // rsv bits
    send_byte(8'h83);                    // unknown opcode
    send_byte(8'h09);                    // fragmented ping
    send_byte(8'h80);                    // orphan continuation
    send_byte(8'h81); send_byte(8'h05);  // unmasked while masked expected
    send_byte(8'h89); send_byte(8'hFE);  // control with extended length
    send_byte(8'h82); send_byte(8'hFE); send_byte(8'h00); send_byte(8'h10); // nonminimal
    send_byte(8'h82); send_byte(8'hFF); send_byte(8'h80); // msb set
    repeat (7) send_byte(8'hFF);
    send_byte(8'h82); send_byte(8'hFF);
    repeat (6) send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'hFF);  // 64-bit form below 65536
  endtask

  task automatic test_close_frames();
    send_frame(1, OPC_CLOSE, 1, 1, 0, 0);
    send_frame(1, OPC_CLOSE, 1, 2, 0, 1);
    send_byte(8'h88); send_byte(8'h82);
    repeat (4) send_byte(8'h00);
    send_byte(8'h03); send_byte(8'hED);  // status 1005
    send_frame(1, OPC_CLOSE, 1, 0, 0, 0);
  endtask

  task automatic test_fragments();
    send_frame(0, OPC_TEXT, 1, 3, 0, 0);
    send_frame(1, OPC_PING, 1, 2, 0, 0);
    send_byte(8'h82);                    // new data during fragment
    send_frame(1, OPC_CONT, 1, 0, 0, 0);
    write_mask_mode(1'b0);
    send_frame(0, OPC_BIN, 0, 2, 0, 0);
    send_frame(1, OPC_CONT, 0, 0, 0, 0); // zero-length final continuation
    send_frame(1, OPC_TEXT, 0, 130, 1, 0);
  endtask

  task automatic test_random_stream();
    int n, sel;
    for (int round = 0; round < 3; round++) begin
      write_mask_mode(round != 1);
      n = bytes_sent;
      while (bytes_sent < n + 160) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) send_byte(8'($urandom));
        else if (sel == 1) send_frame(1'($urandom), 4'($urandom), 1'($urandom),
                                      $urandom_range(0, 3), 0, 0);
        else if (sel == 2) send_frame(1, OPC_CLOSE, mask_req, $urandom_range(0, 4), 0,
                                      1'($urandom));
        else if (sel == 3) send_frame(1, 4'($urandom_range(9, 10)), mask_req,
                                      $urandom_range(0, 6), 0, 0);
        else if (sel == 4) send_frame(1, OPC_TEXT, mask_req, $urandom_range(126, 140), 1, 0);
        else if (sel == 5 && frag_open) send_frame(1'($urandom), OPC_CONT, mask_req,
                                                   $urandom_range(0, 8), 0, 0);
        else send_frame(1'($urandom), 4'($urandom_range(1, 2)), mask_req,
                        $urandom_range(0, 12), 0, 0);
      end
      // sender holds off until the block is drained
      wait_drained();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_valid !== want.data_valid)
          report_mismatch("data_valid", out_data_valid, want.data_valid);
        if (out_data_byte !== want.data_byte)
          report_mismatch("data_byte", out_data_byte, want.data_byte);
        if (out_data_is_control !== want.data_is_control)
          report_mismatch("data_is_control", out_data_is_control, want.data_is_control);
        if (out_message_start !== want.message_start)
          report_mismatch("message_start", out_message_start, want.message_start);
        if (out_message_opcode !== want.message_opcode)
          report_mismatch("message_opcode", out_message_opcode, want.message_opcode);
        if (out_message_end !== want.message_end)
          report_mismatch("message_end", out_message_end, want.message_end);
        if (out_protocol_error !== want.protocol_error)
          report_mismatch("protocol_error", out_protocol_error, want.protocol_error);
        if (out_error_cause !== want.error_cause)
          report_mismatch("error_cause", out_error_cause, want.error_cause);
      end
      results_seen++;
    end
  end

  // receiver stall, drawn per result
  initial begin
    int hold;
    out_stall = 1'b1;
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog on accepted requests
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("[websocket_frame_receiver] ERROR");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_masking_expected = 1'b1;
    error_count = 0; bytes_sent = 0; results_seen = 0; errors_flagged = 0;
    idle_cycles = 0; timed_out = 0;
    mask_req = 1'b1; frag_open = 0; key = 0;
    clear_frame_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_errors();
    test_close_frames();
    test_fragments();
    test_random_stream();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d bytes and %0d results, %0d protocol errors flagged", bytes_sent,
             results_seen, errors_flagged);
    $display("both masking modes, extended lengths, close codes and fragments exercised");
    if (error_count == 0) $display("[websocket_frame_receiver] OK");
    else $display("[websocket_frame_receiver] ERROR");
    $finish;
  end

endmodule
